// File: design/scb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scb_pkg
// shared constants, frame request type and the angle to pulse mapping
// ----------------------------------------------------------------------------
package scb_pkg;

  localparam int SERVO_COUNT_DEF = 17;
  localparam int POSE_COUNT_DEF  = 5;

  localparam int PULSE_W = 14;

  localparam logic [7:0]         HEAD_BYTE   = 8'h80;
  localparam logic [7:0]         MAX_ID      = 8'd17;
  localparam logic [7:0]         LEAVE_BYTE  = 8'd129;
  localparam logic [7:0]         ENTER_TEACH = 8'd128;
  localparam logic [7:0]         ENTER_PLAY  = 8'd3;
  localparam logic [PULSE_W-1:0] PULSE_BASE  = 14'd6000;
  localparam logic [PULSE_W-1:0] PULSE_TEACH = 14'd7500;

  // one three-byte frame handed to the serializer
  typedef struct packed {
    logic [7:0]         head;
    logic [PULSE_W-1:0] pulse;
    logic               last;
  } frame_req_t;

  // pulse = angle * 20 + 6000, as two shifted copies and two adds
  function automatic logic [PULSE_W-1:0] to_pulse(input logic [7:0] angle);
    logic [PULSE_W-1:0] x16;
    logic [PULSE_W-1:0] x4;
    x16 = PULSE_W'({angle, 4'b0000});
    x4  = PULSE_W'({angle, 2'b00});
    return x16 + x4 + PULSE_BASE;
  endfunction

endpackage
`default_nettype wire

// File: design/scb_pose_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scb_pose_ram
// angle store for one pose, one write port and one registered read port
// ----------------------------------------------------------------------------
module scb_pose_ram #(
  parameter int DEPTH = 17,
  parameter int AW    = 5
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // write-first when a read meets a write to the same entry
  always_ff @(posedge clk) begin
    if (re) begin
      if (we && waddr == raddr) begin
        rdata <= wdata;
      end else begin
        rdata <= mem[raddr];
      end
    end
  end

endmodule
`default_nettype wire

// File: design/scb_frame_tx.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scb_frame_tx
// serializes one frame into head, pulse high seven bits, pulse low seven bits
// ----------------------------------------------------------------------------
module scb_frame_tx (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               load,
  input  wire scb_pkg::frame_req_t req,
  output logic                    ready,
  output logic                    tx_valid,
  input  wire logic               tx_stall,
  output logic [7:0]              tx_byte,
  output logic                    last_byte
);
  import scb_pkg::*;

  typedef enum logic [1:0] {
    SEL_HEAD = 2'd0,
    SEL_HI   = 2'd1,
    SEL_LO   = 2'd2
  } byte_sel_t;

  logic       active;
  byte_sel_t  sel;
  frame_req_t frame;
  logic       advance;
  logic       emit;

  assign advance = !tx_valid || !tx_stall;
  assign emit    = active && advance;
  // a new frame may load in the cycle the final byte goes out
  assign ready   = !active || (advance && sel == SEL_LO);

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      tx_valid <= 1'b0;
      sel      <= SEL_HEAD;
    end else begin
      if (emit) begin
        tx_valid <= 1'b1;
        case (sel)
          SEL_HEAD: begin
            tx_byte   <= frame.head;
            last_byte <= 1'b0;
          end
          SEL_HI: begin
            tx_byte   <= {1'b0, frame.pulse[13:7]};
            last_byte <= 1'b0;
          end
          SEL_LO: begin
            tx_byte   <= {1'b0, frame.pulse[6:0]};
            last_byte <= frame.last;
          end
          default: begin
            tx_byte   <= frame.head;
            last_byte <= 1'b0;
          end
        endcase
      end else if (!tx_stall) begin
        tx_valid <= 1'b0;
      end
      if (load) begin
        active <= 1'b1;
        sel    <= SEL_HEAD;
        frame  <= req;
      end else if (emit) begin
        case (sel)
          SEL_HEAD: sel <= SEL_HI;
          SEL_HI:   sel <= SEL_LO;
          default: begin
            sel    <= SEL_HEAD;
            active <= 1'b0;
          end
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// File: design/servo_command_bridge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// servo_command_bridge
// host byte stream to servo-bus command frames, idle / teach / play modes
// ----------------------------------------------------------------------------
// Each host byte is one request on the rx channel; each servo-bus byte is one
// request on the tx channel, with last_byte set on the final byte that a host
// byte causes. Frames are three bytes: head, pulse[13:7], pulse[6:0], with
// pulse = angle*20 + 6000. Bytes that only change mode or buffer an angle are
// taken with no rx hold. A byte that yields one frame (idle 128 or 129, or the
// angle of a teach pair) holds the rx side until the frame serializer takes
// the frame, then the three bytes drain from the tx register while the next
// host byte is already accepted. The byte that completes a pose starts a burst
// of SERVO_COUNT frames read back one entry at a time from the pose memory;
// the serializer, at one tx byte per cycle while tx does not stall, sets the
// pace, and rx is held until the last frame has been handed over. The first
// playback read goes out in the same cycle as the write of the completing
// angle; with a one-servo pose both hit the same entry and the pose memory
// forwards the write data. All other playback reads happen while rx is held,
// so no write can meet them. The pose memory has no reset; every entry is
// written before the burst reads it.
// ----------------------------------------------------------------------------
module servo_command_bridge #(
  parameter int SERVO_COUNT = scb_pkg::SERVO_COUNT_DEF,
  parameter int POSE_COUNT  = scb_pkg::POSE_COUNT_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       rx_valid,
  output logic            rx_stall,
  input  wire logic [7:0] rx_byte,
  output logic            tx_valid,
  input  wire logic       tx_stall,
  output logic      [7:0] tx_byte,
  output logic            last_byte
);
  import scb_pkg::*;

  localparam int IDX_W  = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;
  localparam int PLAY_W = (POSE_COUNT > 1) ? $clog2(POSE_COUNT) : 1;
  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(SERVO_COUNT - 1);
  localparam logic [PLAY_W-1:0] LAST_POSE = PLAY_W'(POSE_COUNT - 1);

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_TEACH = 2'd1,
    MODE_PLAY  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_IN     = 2'd0,  // waiting for a host byte
    ST_SINGLE = 2'd1,  // one frame waits for the serializer
    ST_BURST  = 2'd2   // pose playback, one frame per memory read
  } state_t;

  state_t             state;
  mode_t              mode;
  logic               id_pending;
  logic [4:0]         held_id;
  logic [PLAY_W-1:0]  play_count;
  logic [IDX_W-1:0]   pose_fill;
  logic [IDX_W-1:0]   burst_idx;
  logic [7:0]         pend_head;
  logic [PULSE_W-1:0] pend_pulse;

  logic               rx_acc;
  logic               pose_we;
  logic               pose_done;
  logic               burst_last;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic [7:0]         rd_data;
  logic               frame_ready;
  logic               frame_load;
  frame_req_t         frame_req;

  // request handshake on the host side
  assign rx_stall = (state != ST_IN);
  assign rx_acc   = rx_valid && !rx_stall;

  // angle capture in play mode
  assign pose_we    = rx_acc && (mode == MODE_PLAY);
  assign pose_done  = pose_we && (pose_fill == LAST_IDX);
  assign burst_last = (burst_idx == LAST_IDX);

  // first read goes out with the completing byte, the next with each frame load
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (pose_done) begin
      rd_en = 1'b1;
    end else if (state == ST_BURST && frame_ready && !burst_last) begin
      rd_en   = 1'b1;
      rd_addr = IDX_W'(burst_idx + 1'b1);
    end
  end

  // frame source: held single frame or the current pose entry
  always_comb begin
    frame_load = 1'b0;
    frame_req  = '{head: pend_head, pulse: pend_pulse, last: 1'b1};
    case (state)
      ST_SINGLE: frame_load = frame_ready;
      ST_BURST: begin
        frame_load = frame_ready;
        frame_req  = '{head:  HEAD_BYTE + 8'(burst_idx),
                       pulse: to_pulse(rd_data),
                       last:  burst_last};
      end
      default: frame_load = 1'b0;
    endcase
  end

  scb_pose_ram #(
    .DEPTH (SERVO_COUNT),
    .AW    (IDX_W)
  ) u_pose_ram (
    .clk   (clk),
    .we    (pose_we),
    .waddr (pose_fill),
    .wdata (rx_byte),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  scb_frame_tx u_frame_tx (
    .clk       (clk),
    .rst       (rst),
    .load      (frame_load),
    .req       (frame_req),
    .ready     (frame_ready),
    .tx_valid  (tx_valid),
    .tx_stall  (tx_stall),
    .tx_byte   (tx_byte),
    .last_byte (last_byte)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IN;
      mode       <= MODE_IDLE;
      id_pending <= 1'b0;
      held_id    <= '0;
      play_count <= '0;
      pose_fill  <= '0;
      burst_idx  <= '0;
    end else begin
      case (state)
        ST_IN: begin
          if (rx_acc) begin
            case (mode)
              MODE_TEACH: begin
                if (!id_pending) begin
                  if (rx_byte == LEAVE_BYTE) begin
                    mode <= MODE_IDLE;
                  end else if (rx_byte <= MAX_ID) begin
                    held_id    <= rx_byte[4:0];
                    id_pending <= 1'b1;
                  end
                end else begin
                  // angle of the pair: one frame for the held id
                  pend_head  <= HEAD_BYTE + {3'b000, held_id};
                  pend_pulse <= to_pulse(rx_byte);
                  id_pending <= 1'b0;
                  state      <= ST_SINGLE;
                end
              end
              MODE_PLAY: begin
                if (pose_fill == LAST_IDX) begin
                  pose_fill <= '0;
                  burst_idx <= '0;
                  state     <= ST_BURST;
                  if (play_count == LAST_POSE) begin
                    play_count <= '0;
                    mode       <= MODE_IDLE;
                  end else begin
                    play_count <= PLAY_W'(play_count + 1'b1);
                  end
                end else begin
                  pose_fill <= IDX_W'(pose_fill + 1'b1);
                end
              end
              default: begin
                if (rx_byte == ENTER_TEACH) begin
                  pend_head  <= HEAD_BYTE;
                  pend_pulse <= PULSE_TEACH;
                  mode       <= MODE_TEACH;
                  id_pending <= 1'b0;
                  state      <= ST_SINGLE;
                end else if (rx_byte == ENTER_PLAY) begin
                  mode       <= MODE_PLAY;
                  play_count <= '0;
                  pose_fill  <= '0;
                end else begin
                  // idle, and the unused mode code behaves as idle
                  mode <= MODE_IDLE;
                  if (rx_byte == LEAVE_BYTE) begin
                    pend_head  <= HEAD_BYTE;
                    pend_pulse <= PULSE_BASE;
                    state      <= ST_SINGLE;
                  end
                end
              end
            endcase
          end
        end
        ST_SINGLE: begin
          if (frame_ready) begin
            state <= ST_IN;
          end
        end
        ST_BURST: begin
          if (frame_ready) begin
            if (burst_last) begin
              state <= ST_IN;
            end else begin
              burst_idx <= IDX_W'(burst_idx + 1'b1);
            end
          end
        end
        default: state <= ST_IN;
      endcase
    end
  end

  // a held teach id only exists inside teach mode
  a_id_in_teach: assert property (@(posedge clk) disable iff (rst)
    id_pending |-> mode == MODE_TEACH)
    else $error("teach id held outside teach mode");

  // a completed pose always starts playback
  a_pose_starts_burst: assert property (@(posedge clk) disable iff (rst)
    pose_done |=> state == ST_BURST && burst_idx == '0)
    else $error("completed pose did not start playback");

  // playback index and fill never run past the pose
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    burst_idx <= LAST_IDX && pose_fill <= LAST_IDX)
    else $error("pose index out of range");

  // handing over the final frame reopens the host side
  a_burst_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BURST && frame_ready && burst_last) |=> state == ST_IN)
    else $error("playback did not end after the final frame");

endmodule
`default_nettype wire
